[rtl/pc565_pkg.sv]
package pc565_pkg;

    localparam int unsigned SOURCE_COLORS_DEF = 256;
    localparam int unsigned PALETTE_DEPTH_DEF = 256;

    localparam int unsigned IDX_W   = 8;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned COUNT_W = 9;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        idx_t  pixel_index;
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  image_start;
    } pixel_t;

    typedef struct packed {
        idx_t   out_index;
        logic   new_color;
        color_t color_rgb565;
        count_t color_count;
    } result_t;

    // search word travelling down the cell row
    typedef struct packed {
        logic   active;
        color_t color;
        logic   found;
        idx_t   hit_index;
        color_t last_color;
    } probe_t;

    typedef struct packed {
        logic   clear;
        logic   en;
        idx_t   addr;
        color_t color;
    } cell_wr_t;

    typedef struct packed {
        idx_t   target;
        color_t color;
    } map_entry_t;

    function automatic color_t pack565(chan_t r, chan_t g, chan_t b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[rtl/palette_compactor_rgb565.sv]
// channel  | ports                | handshake
// ---------+----------------------+----------------------------------
// pixel in | pixel (pixel_t)      | taken when start && !busy
// result   | result (result_t)    | one cycle, marked by done
//
// a pixel already mapped goes from accept through S_MAP to done
// an unmapped pixel walks the cell row in S_SEARCH until done
// busy is high from accept until the result word is registered
// reset clears the map valid bits, the cell valid bits and the count
// the receiver cannot stall: done marks each result word for one cycle only
module palette_compactor_rgb565 #(
    parameter int unsigned SOURCE_COLORS = pc565_pkg::SOURCE_COLORS_DEF,
    parameter int unsigned PALETTE_DEPTH = pc565_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pc565_pkg::pixel_t  pixel,
    output logic               done,
    output pc565_pkg::result_t result
);
    import pc565_pkg::*;

    localparam int unsigned SRC_W = $clog2(SOURCE_COLORS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MAP    = 3'b010,
        S_SEARCH = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       map_valid_reg [SOURCE_COLORS];
    map_entry_t map_mem [SOURCE_COLORS];
    map_entry_t map_rd_reg;
    count_t     count_reg;
    count_t     count_next;
    color_t     color_reg;
    logic [SRC_W-1:0] waddr_reg;
    logic       in_map_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       done_reg;
    logic       done_next;

    logic       acc;
    logic       in_map_in;
    logic       mapped_in;
    logic [SRC_W-1:0] map_addr;
    logic       finish;
    idx_t       tgt;
    color_t     tgt_color;
    logic       app;
    logic       map_we;
    cell_wr_t   cell_wr;
    probe_t     chain [PALETTE_DEPTH+1];

    assign acc       = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign in_map_in = {1'b0, pixel.pixel_index} < COUNT_W'(SOURCE_COLORS);
    assign map_addr  = pixel.pixel_index[SRC_W-1:0];
    assign mapped_in = in_map_in && !pixel.image_start && map_valid_reg[map_addr];

    // search enters the first cell in the accept cycle
    always_comb
    begin
        chain[0]        = '0;
        chain[0].active = acc && !mapped_in;
        chain[0].color  = pack565(pixel.red, pixel.green, pixel.blue);
    end

    genvar gi;
    generate
        for (gi = 0; gi < PALETTE_DEPTH; gi++)
        begin : g_cell
            pc565_cell #(
                .CELL_INDEX(gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (cell_wr),
                .probe_in (chain[gi]),
                .probe_out(chain[gi+1])
            );
        end
    endgenerate

    assign finish = (state_reg == S_SEARCH) && chain[PALETTE_DEPTH].active;

    always_comb
    begin
        tgt       = chain[PALETTE_DEPTH].hit_index;
        tgt_color = color_reg;
        app       = 1'b0;
        if (!chain[PALETTE_DEPTH].found)
        begin
            if (count_reg < COUNT_W'(PALETTE_DEPTH))
            begin
                tgt = count_reg[IDX_W-1:0];
                app = 1'b1;
            end
            else
            begin
                // palette full: fold onto the last entry
                tgt       = IDX_W'(PALETTE_DEPTH - 1);
                tgt_color = chain[PALETTE_DEPTH].last_color;
            end
        end
    end

    always_comb
    begin
        cell_wr.clear = acc && pixel.image_start;
        cell_wr.en    = finish && app;
        cell_wr.addr  = tgt;
        cell_wr.color = color_reg;
    end

    assign map_we = finish && in_map_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (pixel.image_start)
                    begin
                        count_next = '0;
                    end
                    state_next = mapped_in ? S_MAP : S_SEARCH;
                end
            end
            S_MAP:
            begin
                result_next.out_index    = map_rd_reg.target;
                result_next.new_color    = 1'b0;
                result_next.color_rgb565 = map_rd_reg.color;
                result_next.color_count  = count_reg;
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end
            S_SEARCH:
            begin
                if (finish)
                begin
                    count_next               = count_reg + COUNT_W'(app);
                    result_next.out_index    = tgt;
                    result_next.new_color    = app;
                    result_next.color_rgb565 = tgt_color;
                    result_next.color_count  = count_reg + COUNT_W'(app);
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCE_COLORS; i++)
            begin
                map_valid_reg[i] <= 1'b0;
            end
        end
        else if (acc && pixel.image_start)
        begin
            for (int i = 0; i < SOURCE_COLORS; i++)
            begin
                map_valid_reg[i] <= 1'b0;
            end
        end
        else if (map_we)
        begin
            map_valid_reg[waddr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[waddr_reg] <= '{target: tgt, color: tgt_color};
        end
        if (acc)
        begin
            map_rd_reg <= map_mem[map_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (acc)
        begin
            color_reg  <= pack565(pixel.red, pixel.green, pixel.blue);
            waddr_reg  <= map_addr;
            in_map_reg <= in_map_in;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/pc565_cell.sv]
module pc565_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pc565_pkg::cell_wr_t wr,
    input  pc565_pkg::probe_t   probe_in,
    output pc565_pkg::probe_t   probe_out
);
    import pc565_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    color_t entry_reg;
    color_t entry_next;
    probe_t probe_reg;
    probe_t probe_next;
    logic   sel;
    logic   hit;

    assign sel = wr.en && (wr.addr == IDX_W'(CELL_INDEX));

    // a clear arrives together with the probe at the first cell
    assign hit = probe_in.active && valid_reg && !wr.clear && !probe_in.found
                 && (entry_reg == probe_in.color);

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.clear)
        begin
            valid_next = 1'b0;
        end
        else if (sel)
        begin
            valid_next = 1'b1;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (sel)
        begin
            entry_next = wr.color;
        end
    end

    always_comb
    begin
        probe_next            = probe_in;
        probe_next.last_color = entry_reg;
        if (hit)
        begin
            probe_next.found     = 1'b1;
            probe_next.hit_index = IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign probe_out = probe_reg;

endmodule
